@@ src/mpf_pkg.sv @@
// Package: shared constants and types for the page frame store.
`timescale 1ns / 1ps
package mpf_pkg;
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  localparam int HEADER_LEN  = 3;

  localparam logic [2:0] CMD_POINT = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_START = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [7:0] PAGE_CMD_BASE = 8'hb0;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

  localparam logic [1:0] ADDR_OFFSET = 2'd0;
  localparam logic [1:0] ADDR_ROTATE = 2'd1;

  // One classified request handed from front to back.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] xs;
    logic [7:0] ys;
    logic [7:0] xe;
    logic [7:0] ye;
    logic       on;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_WR, ST_TRD, ST_TOUT
  } state_t;
endpackage

@@ src/mpf_front.sv @@
// Front end: accept requests, drop unused codes, queue the rest.
`timescale 1ns / 1ps
module mpf_front #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mpf_pkg::req_t  in_req,
  output logic           q_valid,
  input  logic           q_ready,
  output mpf_pkg::req_t  q_req
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  mpf_pkg::req_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push, pop, keep;

  assign keep     = (in_req.cmd <= mpf_pkg::CMD_TICK);
  assign in_ready = (count != (AW+1)'(DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_req    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ src/mpf_back.sv @@
// Back end: frame memory, drawing sequencer and refresh byte generator.
`timescale 1ns / 1ps
module mpf_back #(
  parameter int COLUMNS = mpf_pkg::COLUMNS_DEF,
  parameter int PAGES   = mpf_pkg::PAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  mpf_pkg::req_t q_req,
  input  logic [6:0]    column_offset,
  input  logic [6:0]    column_rotate,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          is_data,
  output logic          frame_last
);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROWS  = PAGES * 8;
  localparam int POSW  = $clog2(COLUMNS + mpf_pkg::HEADER_LEN);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  mpf_pkg::state_t state, state_next;
  mpf_pkg::req_t   cur;

  // drawing walk
  logic [8:0] col, col_lo, col_hi;
  logic [8:0] row_lo, row_hi;
  logic [PW-1:0] wpage;
  logic [AW:0]   clr_idx;

  // refresh state
  logic          ref_active;
  logic [PW-1:0] ref_page;
  logic [POSW-1:0] ref_pos;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  wdata;

  // row range of the current page and its bit mask
  logic [8:0] pg_top, pg_bot, r0, r1;
  logic [7:0] mask;
  logic       page_hit;

  always_comb begin
    pg_top = 9'(PAGES - 1 - int'(wpage)) << 3;
    pg_bot = pg_top + 9'd7;
    r0 = (row_lo > pg_top) ? row_lo : pg_top;
    r1 = (row_hi < pg_bot) ? row_hi : pg_bot;
    page_hit = (r0 <= r1);
    for (int b = 0; b < 8; b++) begin
      mask[7-b] = page_hit && (pg_top + 9'(b) >= r0) && (pg_top + 9'(b) <= r1);
    end
  end

  logic [CW-1:0] dcol;
  logic [POSW-1:0] n_idx;
  logic [9:0]      rot_sum;
  assign n_idx = ref_pos - POSW'(mpf_pkg::HEADER_LEN);

  // wrap the rotated column back onto the panel
  always_comb begin
    rot_sum = 10'(n_idx) + 10'(column_rotate);
    for (int k = 0; k < 1 + 127 / COLUMNS; k++) begin
      if (rot_sum >= 10'(COLUMNS)) rot_sum = rot_sum - 10'(COLUMNS);
    end
  end
  assign dcol = rot_sum[CW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  always_comb begin
    raddr = AW'(int'(wpage) * COLUMNS + int'(col));
    if (state == mpf_pkg::ST_TRD || (state == mpf_pkg::ST_IDLE))
      raddr = AW'(int'(ref_page) * COLUMNS + int'(dcol));
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(int'(wpage) * COLUMNS + int'(col));
    wdata = cur.on ? (rd_data | mask) : (rd_data & ~mask);
    if (state == mpf_pkg::ST_CLEAR) begin
      we = 1'b1;
      waddr = clr_idx[AW-1:0];
      wdata = 8'h00;
    end else if (state == mpf_pkg::ST_WR) begin
      we = 1'b1;
    end
  end

  always_comb begin
    q_ready = (state == mpf_pkg::ST_IDLE);
  end

  logic last_col, last_page;
  assign last_col  = (col == col_hi);
  assign last_page = (wpage == PW'(PAGES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      mpf_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_req.cmd)
            mpf_pkg::CMD_CLEAR: state_next = mpf_pkg::ST_CLEAR;
            mpf_pkg::CMD_POINT: begin
              if (32'(q_req.xs) < COLUMNS && 32'(q_req.ys) < ROWS)
                state_next = mpf_pkg::ST_RD;
            end
            mpf_pkg::CMD_FILL: begin
              if (q_req.xs <= q_req.xe && q_req.ys <= q_req.ye &&
                  32'(q_req.xs) < COLUMNS && 32'(q_req.ys) < ROWS)
                state_next = mpf_pkg::ST_RD;
            end
            mpf_pkg::CMD_TICK: if (ref_active) state_next = mpf_pkg::ST_TRD;
            default: state_next = mpf_pkg::ST_IDLE;
          endcase
        end
      end
      mpf_pkg::ST_CLEAR:
        if (clr_idx == (AW+1)'(DEPTH - 1)) state_next = mpf_pkg::ST_IDLE;
      mpf_pkg::ST_RD: state_next = mpf_pkg::ST_WR;
      mpf_pkg::ST_WR:
        if (last_col && (last_page || cur.cmd == mpf_pkg::CMD_POINT))
          state_next = mpf_pkg::ST_IDLE;
        else state_next = mpf_pkg::ST_RD;
      mpf_pkg::ST_TRD: state_next = mpf_pkg::ST_TOUT;
      mpf_pkg::ST_TOUT: if (out_ready) state_next = mpf_pkg::ST_IDLE;
      default: state_next = mpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state == mpf_pkg::ST_TOUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // sweep the store to zero straight out of reset
      state      <= mpf_pkg::ST_CLEAR;
      ref_active <= 1'b0;
      ref_page   <= '0;
      ref_pos    <= '0;
      clr_idx    <= '0;
    end else begin
      state <= state_next;
      if (state == mpf_pkg::ST_IDLE && q_valid) begin
        cur <= q_req;
        clr_idx <= '0;
        if (q_req.cmd == mpf_pkg::CMD_FILL || q_req.cmd == mpf_pkg::CMD_CLEAR ||
            q_req.cmd == mpf_pkg::CMD_START) begin
          ref_active <= 1'b1;
          ref_page   <= '0;
          ref_pos    <= '0;
        end
        if (q_req.cmd == mpf_pkg::CMD_POINT) begin
          col    <= {1'b0, q_req.xs};
          col_lo <= {1'b0, q_req.xs};
          col_hi <= {1'b0, q_req.xs};
          row_lo <= {1'b0, q_req.ys};
          row_hi <= {1'b0, q_req.ys};
          wpage  <= PW'(PAGES - 1 - int'(q_req.ys[7:3]));
          // point touches a single page: walk just that one
        end else begin
          col    <= {1'b0, q_req.xs};
          col_lo <= {1'b0, q_req.xs};
          col_hi <= (32'(q_req.xe) >= COLUMNS) ? 9'(COLUMNS - 1) : {1'b0, q_req.xe};
          row_lo <= {1'b0, q_req.ys};
          row_hi <= (32'(q_req.ye) >= ROWS) ? 9'(ROWS - 1) : {1'b0, q_req.ye};
          wpage  <= '0;
        end
      end
      if (state == mpf_pkg::ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == mpf_pkg::ST_WR) begin
        if (last_col) begin
          col <= col_lo;
          if (cur.cmd == mpf_pkg::CMD_POINT) wpage <= PW'(PAGES - 1);
          else wpage <= wpage + 1'b1;
        end else begin
          col <= col + 9'd1;
        end
      end
      if (state == mpf_pkg::ST_TRD) begin
        // data byte comes from the memory read issued while idle
        unique case (ref_pos)
          POSW'(0): out_byte <= mpf_pkg::PAGE_CMD_BASE + 8'(ref_page);
          POSW'(1): out_byte <= {4'h0, column_offset[3:0]};
          POSW'(2): out_byte <= mpf_pkg::COL_HIGH_CMD | {5'd0, column_offset[6:4]};
          default:  out_byte <= rd_data;
        endcase
        is_data    <= (ref_pos >= POSW'(mpf_pkg::HEADER_LEN));
        frame_last <= 1'b0;
        if (ref_pos == POSW'(COLUMNS + mpf_pkg::HEADER_LEN - 1)) begin
          ref_pos <= '0;
          if (ref_page == PW'(PAGES - 1)) begin
            ref_page   <= '0;
            ref_active <= 1'b0;
            frame_last <= 1'b1;
          end else begin
            ref_page <= ref_page + 1'b1;
          end
        end else begin
          ref_pos <= ref_pos + 1'b1;
        end
      end
    end
  end
endmodule

@@ src/mpf_regs.sv @@
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module mpf_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  column_offset,
  output logic [6:0]  column_rotate
);
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= 7'd2;
      column_rotate <= 7'd1;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == mpf_pkg::ADDR_OFFSET[0]) column_offset <= pwdata[6:0];
      else column_rotate <= pwdata[6:0];
    end
  end

  always_comb begin
    case (paddr[2])
      mpf_pkg::ADDR_ROTATE[0]: prdata = {25'd0, column_rotate};
      default:                 prdata = {25'd0, column_offset};
    endcase
  end
endmodule

@@ src/monochrome_page_framebuffer_core.sv @@
// Top level: page-mode monochrome frame store with refresh byte stream.
//  channel | signals                         | moves
//  in      | in_valid/in_ready + cmd..pixel_on | one drawing or refresh request
//  out     | out_valid/out_ready + out_byte..  | one panel byte per tick
//  cfg     | psel/penable/pwrite/paddr/pwdata  | column offset and rotate
// A tick goes through three steps: take it (memory read issued), register the
// byte, offer it; a stalled receiver holds the back end on the offered byte.
// A point is taken, read and written; a fill is taken, then each byte of its column
// span on every page is read and written; a clear zeroes all COLUMNS*PAGES bytes.
// Reset is synchronous: refresh goes idle and the store is swept to zero, one byte a
// cycle, all COLUMNS*PAGES bytes; the front queue takes up to two requests meanwhile.
// The front queue takes up to two requests while the back end is busy or stalled.
`timescale 1ns / 1ps
module monochrome_page_framebuffer_core #(
  parameter int COLUMNS = mpf_pkg::COLUMNS_DEF,
  parameter int PAGES   = mpf_pkg::PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [7:0]  x_end,
  input  logic [7:0]  y_end,
  input  logic        pixel_on,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  mpf_pkg::req_t in_req, q_req;
  logic q_valid, q_ready;
  logic [6:0] column_offset, column_rotate;

  assign in_req = '{cmd: cmd, xs: x_start, ys: y_start, xe: x_end, ye: y_end,
                    on: pixel_on};

  mpf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .column_offset, .column_rotate
  );

  mpf_front #(.DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_req, .q_valid, .q_ready, .q_req
  );

  mpf_back #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req, .column_offset, .column_rotate,
    .out_valid, .out_ready, .out_byte, .is_data, .frame_last
  );
endmodule

@@ test/mpf_stream_checker.sv @@
// Checker: mirrors the frame store and compares the panel byte stream.
`timescale 1ns / 1ps
module mpf_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [7:0]  x_end,
  input  logic [7:0]  y_end,
  input  logic        pixel_on,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        is_data,
  input  logic        frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  localparam int COLS = mpf_pkg::COLUMNS_DEF;
  localparam int PGS  = mpf_pkg::PAGES_DEF;
  localparam int ROWS = PGS * 8;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       data;
    logic       last;
  } panel_byte_t;

  logic [7:0]  frame_mirror [0:COLS*PGS-1];
  logic [2:0]  scan_page;
  int          scan_pos;
  logic        scanning;
  logic [6:0]  col_offset;
  logic [6:0]  col_rotate;
  panel_byte_t expected_bytes[$];

  assign pending = expected_bytes.size();

  function automatic void plot(int x, int y, logic on);
    int idx;
    if (x >= COLS || y >= ROWS) return;
    idx = (PGS - 1 - y / 8) * COLS + x;
    frame_mirror[idx][7 - y % 8] = on;
  endfunction

  function automatic void restart_scan();
    scan_page = '0;
    scan_pos  = 0;
    scanning  = 1'b1;
  endfunction

  // Apply one accepted request to the mirror; queue the byte a tick yields.
  task automatic apply_request(logic [2:0] c, int xs, int ys, int xe, int ye, logic on);
    panel_byte_t pb;
    int col;
    pb = '0;
    case (c)
      mpf_pkg::CMD_POINT: plot(xs, ys, on);
      mpf_pkg::CMD_FILL: begin
        if (xe >= COLS) xe = COLS - 1;
        if (ye >= ROWS) ye = ROWS - 1;
        for (int x = xs; x <= xe; x++)
          for (int y = ys; y <= ye; y++) plot(x, y, on);
        restart_scan();
      end
      mpf_pkg::CMD_CLEAR: begin
        foreach (frame_mirror[i]) frame_mirror[i] = '0;
        restart_scan();
      end
      mpf_pkg::CMD_START: restart_scan();
      mpf_pkg::CMD_TICK: if (scanning) begin
        if (scan_pos == 0) pb.pbyte = mpf_pkg::PAGE_CMD_BASE + 8'(scan_page);
        else if (scan_pos == 1) pb.pbyte = {4'h0, col_offset[3:0]};
        else if (scan_pos == 2) pb.pbyte = mpf_pkg::COL_HIGH_CMD | {5'd0, col_offset[6:4]};
        else begin
          col = (scan_pos - mpf_pkg::HEADER_LEN + col_rotate) % COLS;
          pb.pbyte = frame_mirror[scan_page * COLS + col];
          pb.data = 1'b1;
        end
        scan_pos++;
        if (scan_pos >= mpf_pkg::HEADER_LEN + COLS) begin
          scan_pos = 0;
          if (scan_page == 3'(PGS - 1)) begin
            scan_page = '0;
            scanning = 1'b0;
            pb.last = 1'b1;
          end else scan_page++;
        end
        expected_bytes.push_back(pb);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    panel_byte_t exp_b;
    if (rst) begin
      foreach (frame_mirror[i]) frame_mirror[i] = '0;
      scan_page = '0;
      scan_pos = 0;
      scanning = 1'b0;
      col_offset = 7'd2;
      col_rotate = 7'd1;
      expected_bytes.delete();
      fail_count = 0;
    end else begin
      // compare first: a result never stems from a request taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected panel byte %02h data %0b last %0b",
                     out_byte, is_data, frame_last);
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_byte !== exp_b.pbyte || is_data !== exp_b.data ||
              frame_last !== exp_b.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("panel byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                       exp_b.pbyte, exp_b.data, exp_b.last, out_byte, is_data, frame_last);
          end
        end
      end
      if (in_valid && in_ready)
        apply_request(cmd, x_start, y_start, x_end, y_end, pixel_on);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2:2] == mpf_pkg::ADDR_OFFSET[0]) col_offset = pwdata[6:0];
        else col_rotate = pwdata[6:0];
      end
    end
  end
endmodule

@@ test/tb_monochrome_page_framebuffer_core.sv @@
// Testbench top: request stimulus, register writes and the verdict.
`timescale 1ns / 1ps
module tb_monochrome_page_framebuffer_core;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int SETTLE       = 3000;   // longer than a full fill walk
  localparam int PHASE_BUDGET = 60;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [2:0]  cmd;
  logic [7:0]  x_start, y_start, x_end, y_end;
  logic        pixel_on;
  logic        out_valid, out_ready;
  logic [7:0]  out_byte;
  logic        is_data, frame_last;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fail_count, pending;
  int          cycle_count;
  int          issued;
  int          seq_count;
  logic        quiet;

  monochrome_page_framebuffer_core dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .x_start, .y_start, .x_end, .y_end,
    .pixel_on, .out_valid, .out_ready, .out_byte, .is_data, .frame_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mpf_stream_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .cmd, .x_start, .y_start, .x_end, .y_end,
    .pixel_on, .out_valid, .out_ready, .out_byte, .is_data, .frame_last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Count cycles; give up well beyond the slowest correct run.
  // Hold idling off for a stretch so back-to-back traffic is also covered.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    quiet <= (cycle_count > 6000 && cycle_count < 14000);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("monochrome_page_framebuffer_core test failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off once the stream is under way
  // so the request queue fills and in_ready drops.
  initial begin
    int taken;
    int hold;
    taken = 0;
    hold = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (taken == 200 && hold == 0) hold = 600;
      if (hold > 1) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (hold == 1) hold = -1;
        out_ready <= quiet || ($urandom_range(99) >= 13);
      end
    end
  end

  // Offer one request and hold it until it is taken.
  task automatic send_req(logic [2:0] c, logic [7:0] xs, logic [7:0] ys,
                          logic [7:0] xe, logic [7:0] ye, logic on);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    x_start  <= xs;
    y_start  <= ys;
    x_end    <= xe;
    y_end    <= ye;
    pixel_on <= on;
    do @(posedge clk); while (!in_ready);
    if (c <= mpf_pkg::CMD_TICK) issued++;
  endtask

  task automatic send_tick();
    send_req(mpf_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             1'($urandom));
  endtask

  // Register write: setup phase, then access phase.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx[0], 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain everything, then let any silent fill or clear finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly on-panel coordinates, now and then the full field range.
  function automatic logic [7:0] pick_x();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127));
  endfunction

  function automatic logic [7:0] pick_y();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(63));
  endfunction

  // One drawing burst, a refresh restart, then a run of ticks.
  task automatic draw_and_scan(bit full_frame);
    int draws;
    int ticks;
    logic [7:0] xa, ya;
    draws = $urandom_range(6);
    for (int i = 0; i < draws; i++) begin
      xa = pick_x();
      ya = pick_y();
      if ($urandom_range(4) == 0)
        send_req(mpf_pkg::CMD_FILL, xa, ya, xa + 8'($urandom_range(12)),
                 ya + 8'($urandom_range(12)), 1'($urandom));
      else
        send_req(mpf_pkg::CMD_POINT, xa, ya, 8'($urandom), 8'($urandom), 1'($urandom));
    end
    case ($urandom_range(9))
      0: send_req(mpf_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom));
      1, 2: send_req(mpf_pkg::CMD_FILL, pick_x(), pick_y(), pick_x(), pick_y(),
                     1'($urandom));
      default: send_req(mpf_pkg::CMD_START, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 1'($urandom));
    endcase
    // two spare ticks after a full frame land on an idle refresh
    ticks = full_frame ? mpf_pkg::PAGES_DEF * (mpf_pkg::HEADER_LEN + mpf_pkg::COLUMNS_DEF) + 2
                       : $urandom_range(1, 120);
    for (int i = 0; i < ticks; i++) begin
      // points mid-refresh update bytes still to come
      if ($urandom_range(19) == 0)
        send_req(mpf_pkg::CMD_POINT, pick_x(), pick_y(), 8'($urandom), 8'($urandom),
                 1'($urandom));
      send_tick();
    end
  endtask

  initial begin
    logic [6:0] offsets [4];
    logic [6:0] rotates [4];
    offsets = '{7'd2, 7'd0, 7'd127, 7'd0};
    rotates = '{7'd1, 7'd127, 7'd0, 7'd0};
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = mpf_pkg::CMD_TICK;
    x_start = '0;
    y_start = '0;
    x_end = '0;
    y_end = '0;
    pixel_on = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycle_count = 0;
    quiet = 1'b0;
    issued = 0;
    seq_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: edge points, clipped and empty fills, unused codes.
    send_req(mpf_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_req(mpf_pkg::CMD_POINT, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1);
    send_req(mpf_pkg::CMD_POINT, 8'd127, 8'd63, 8'hff, 8'hff, 1'b1);
    send_req(mpf_pkg::CMD_POINT, 8'd128, 8'd5, 8'h00, 8'h00, 1'b1);    // column off panel
    send_req(mpf_pkg::CMD_POINT, 8'd5, 8'd64, 8'h00, 8'h00, 1'b1);     // row off panel
    send_req(mpf_pkg::CMD_POINT, 8'd255, 8'd255, 8'h00, 8'h00, 1'b1);
    send_req(mpf_pkg::CMD_POINT, 8'd127, 8'd63, 8'h00, 8'h00, 1'b0);
    send_req(mpf_pkg::CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1);     // clipped to panel
    send_req(mpf_pkg::CMD_FILL, 8'd20, 8'd0, 8'd10, 8'd63, 1'b0);      // empty in x
    send_req(mpf_pkg::CMD_FILL, 8'd0, 8'd40, 8'd127, 8'd30, 1'b0);     // empty in y
    send_req(mpf_pkg::CMD_FILL, 8'd3, 8'd10, 8'd3, 8'd10, 1'b0);       // single pixel
    send_req(mpf_pkg::CMD_FILL, 8'd100, 8'd50, 8'd200, 8'd200, 1'b0);
    send_req(mpf_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    for (int i = 0; i < 5; i++) send_tick();
    send_req(3'd5, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);         // unused codes
    send_req(3'd6, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_req(3'd7, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_tick();

    // Random phases, each under a different column setting.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        drain();
        if (ph == 3) begin
          offsets[3] = 7'($urandom);
          rotates[3] = 7'($urandom);
        end
        reg_write(mpf_pkg::ADDR_OFFSET, {25'($urandom), offsets[ph]});
        reg_write(mpf_pkg::ADDR_ROTATE, {25'($urandom), rotates[ph]});
      end
      issued = 0;
      while (issued < PHASE_BUDGET) begin
        draw_and_scan(ph == 0 && issued == 0);
        seq_count++;
        // occasional noise between sequences
        if ($urandom_range(7) == 0)
          send_req(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 1'($urandom));
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("monochrome_page_framebuffer_core test passed");
    else
      $display("monochrome_page_framebuffer_core test failed");
    $finish;
  end
endmodule
